@@ rtl/nfsqc_pkg.sv @@
// Package with shared types, codes and arithmetic helpers for the quadratic character evaluator.
`default_nettype none
package nfsqc_pkg;

    localparam int unsigned DW = 64;
    localparam int unsigned CW = 6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_SIGN    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic [DW-1:0] CODE_ZERO      = 64'd0;
    localparam logic [DW-1:0] CODE_ONE       = 64'd1;
    localparam logic [DW-1:0] CODE_SIGN_RAT  = 64'd2;
    localparam logic [DW-1:0] CODE_B_ZERO    = 64'd3;
    localparam logic [DW-1:0] CODE_SIGN_BASE = 64'd1024;
    localparam logic [DW-1:0] CODE_SIGN_END  = 64'd2048;

    typedef struct packed {
        logic load;
        logic red;
        logic nega;
        logic mul;
        logic suba;
        logic kron;
        logic jac;
        logic fin_zero;
        logic fin_sym;
    } nfsqc_cmd_t;

    typedef struct packed {
        logic p_zero;
        logic cnt_zero;
        logic n_even;
        logic n_one;
        logic x_even;
        logic x_zero;
    } nfsqc_stat_t;

    function automatic logic [DW-1:0] red_step(input logic [DW-1:0] rem, input logic bin,
                                               input logic [DW-1:0] m);
        logic [DW:0] sh;
        begin
            sh = {rem, bin};
            if (sh >= {1'b0, m})
            begin
                sh = sh - {1'b0, m};
            end
            return sh[DW-1:0];
        end
    endfunction

    function automatic logic [DW-1:0] add_mod(input logic [DW-1:0] x, input logic [DW-1:0] y,
                                              input logic [DW-1:0] m);
        logic [DW:0] s;
        begin
            s = {1'b0, x} + {1'b0, y};
            if (s >= {1'b0, m})
            begin
                s = s - {1'b0, m};
            end
            return s[DW-1:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/nfs_quadratic_character_eval.sv @@
// Top level of the quadratic character evaluator: controller, datapath and checks.
`default_nettype none
// An item is taken when start is high while busy is low; its result appears on char_bit and
// status for one cycle with done high, and must be captured then. A special character (zero
// prime) goes straight from the idle state to the done state. Otherwise the item runs the
// bit-serial reduction of a, b and r modulo p, the bit-serial modular multiply and the binary
// Kronecker loop, which does one halving or subtraction per step and whose length depends
// on the operands.
module nfs_quadratic_character_eval
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [nfsqc_pkg::DW-1:0]  coord_a,
    input  wire logic [nfsqc_pkg::DW-1:0]  coord_b,
    input  wire logic [nfsqc_pkg::DW-1:0]  char_prime,
    input  wire logic [nfsqc_pkg::DW-1:0]  char_root,
    output logic                           done,
    output logic                           char_bit,
    output logic [1:0]                     status
);
    import nfsqc_pkg::*;

    nfsqc_cmd_t  cmd;
    nfsqc_stat_t stat;

    nfsqc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    nfsqc_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .coord_a    (coord_a),
        .coord_b    (coord_b),
        .char_prime (char_prime),
        .char_root  (char_root),
        .cmd        (cmd),
        .stat       (stat),
        .char_bit   (char_bit),
        .status     (status)
    );

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("block still busy after a result");

    a_special_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && char_prime == '0) |=> done)
        else $error("special character did not finish in one step");

    a_err_bit_low: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> !char_bit)
        else $error("error result carries a set character bit");

endmodule
`default_nettype wire

@@ rtl/nfsqc_ctrl.sv @@
// Controller state machine that sequences reduction, multiplication and the symbol loop.
`default_nettype none
module nfsqc_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  nfsqc_pkg::nfsqc_stat_t    stat,
    output nfsqc_pkg::nfsqc_cmd_t     cmd,
    output logic                      busy,
    output logic                      done
);
    import nfsqc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_REDUCE = 8'b00000010,
        S_NEGA   = 8'b00000100,
        S_MUL    = 8'b00001000,
        S_SUBA   = 8'b00010000,
        S_KRON   = 8'b00100000,
        S_JAC    = 8'b01000000,
        S_DONE   = 8'b10000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.p_zero ? S_DONE : S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                cmd.red = 1'b1;
                if (stat.cnt_zero)
                begin
                    state_next = S_NEGA;
                end
            end
            S_NEGA:
            begin
                cmd.nega   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                if (stat.cnt_zero)
                begin
                    state_next = S_SUBA;
                end
            end
            S_SUBA:
            begin
                cmd.suba   = 1'b1;
                state_next = S_KRON;
            end
            S_KRON:
            begin
                if (stat.n_even)
                begin
                    if (stat.x_even)
                    begin
                        cmd.fin_zero = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.kron = 1'b1;
                    end
                end
                else if (stat.n_one)
                begin
                    cmd.fin_sym = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_JAC;
                end
            end
            S_JAC:
            begin
                if (stat.x_zero)
                begin
                    cmd.fin_sym  = stat.n_one;
                    cmd.fin_zero = !stat.n_one;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.jac = 1'b1;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule
`default_nettype wire

@@ rtl/nfsqc_dp.sv @@
// Datapath with the modular reducers, the modular multiplier and the binary symbol loop.
`default_nettype none
module nfsqc_dp
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [nfsqc_pkg::DW-1:0]      coord_a,
    input  wire logic [nfsqc_pkg::DW-1:0]      coord_b,
    input  wire logic [nfsqc_pkg::DW-1:0]      char_prime,
    input  wire logic [nfsqc_pkg::DW-1:0]      char_root,
    input  nfsqc_pkg::nfsqc_cmd_t              cmd,
    output nfsqc_pkg::nfsqc_stat_t             stat,
    output logic                               char_bit,
    output logic [1:0]                         status
);
    import nfsqc_pkg::*;

    logic [DW-1:0] a_mag_reg;
    logic          a_neg_reg;
    logic [DW-1:0] b_reg;
    logic [DW-1:0] r_reg;
    logic [DW-1:0] p_reg;
    logic [DW-1:0] ra_reg;
    logic [DW-1:0] rb_reg;
    logic [DW-1:0] rr_reg;
    logic [DW-1:0] acc_reg;
    logic [DW-1:0] x_reg;
    logic [DW-1:0] n_reg;
    logic          t_reg;
    logic [CW-1:0] cnt_reg;
    logic          bit_reg;
    logic [1:0]    status_reg;

    logic          sp_bit;
    logic [1:0]    sp_status;
    logic [DW-1:0] mul_dbl;
    logic [DW-1:0] mul_next;
    logic          flip_n8;
    logic          flip_x8;

    always_comb
    begin
        sp_bit    = 1'b0;
        sp_status = ST_OK;
        if (char_root == CODE_ZERO)
        begin
            sp_bit = 1'b0;
        end
        else if (char_root == CODE_ONE)
        begin
            sp_bit = 1'b1;
        end
        else if (char_root == CODE_SIGN_RAT ||
                 (char_root >= CODE_SIGN_BASE && char_root < CODE_SIGN_END))
        begin
            sp_status = ST_SIGN;
        end
        else if (char_root == CODE_B_ZERO)
        begin
            sp_bit = (coord_b == '0);
        end
        else
        begin
            sp_status = ST_UNKNOWN;
        end
    end

    assign mul_dbl  = add_mod(acc_reg, acc_reg, p_reg);
    assign mul_next = rr_reg[cnt_reg] ? add_mod(mul_dbl, rb_reg, p_reg) : mul_dbl;
    assign flip_n8  = (n_reg[2:0] == 3'd3) || (n_reg[2:0] == 3'd5);
    assign flip_x8  = (x_reg[2:0] == 3'd3) || (x_reg[2:0] == 3'd5);

    assign stat.p_zero   = (char_prime == '0);
    assign stat.cnt_zero = (cnt_reg == '0);
    assign stat.n_even   = !n_reg[0];
    assign stat.n_one    = (n_reg == {{(DW-1){1'b0}}, 1'b1});
    assign stat.x_even   = !x_reg[0];
    assign stat.x_zero   = (x_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            bit_reg    <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cmd.load)
            begin
                cnt_reg    <= '1;
                bit_reg    <= sp_bit;
                status_reg <= sp_status;
            end
            else if (cmd.red || cmd.mul)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else if (cmd.nega)
            begin
                cnt_reg <= '1;
            end
            if (cmd.fin_zero)
            begin
                bit_reg    <= 1'b0;
                status_reg <= ST_ZERO;
            end
            else if (cmd.fin_sym)
            begin
                bit_reg    <= t_reg;
                status_reg <= ST_OK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_neg_reg <= coord_a[DW-1];
            a_mag_reg <= coord_a[DW-1] ? (~coord_a + 1'b1) : coord_a;
            b_reg     <= coord_b;
            r_reg     <= char_root;
            p_reg     <= char_prime;
            ra_reg    <= '0;
            rb_reg    <= '0;
            rr_reg    <= '0;
        end
        if (cmd.red)
        begin
            ra_reg <= red_step(ra_reg, a_mag_reg[cnt_reg], p_reg);
            rb_reg <= red_step(rb_reg, b_reg[cnt_reg], p_reg);
            rr_reg <= red_step(rr_reg, r_reg[cnt_reg], p_reg);
        end
        if (cmd.nega)
        begin
            if (a_neg_reg && ra_reg != '0)
            begin
                ra_reg <= p_reg - ra_reg;
            end
            acc_reg <= '0;
        end
        if (cmd.mul)
        begin
            acc_reg <= mul_next;
        end
        if (cmd.suba)
        begin
            x_reg <= acc_reg - ra_reg + ((acc_reg >= ra_reg) ? '0 : p_reg);
            n_reg <= p_reg;
            t_reg <= 1'b0;
        end
        if (cmd.kron)
        begin
            n_reg <= n_reg >> 1;
            t_reg <= t_reg ^ flip_x8;
        end
        if (cmd.jac)
        begin
            if (!x_reg[0])
            begin
                x_reg <= x_reg >> 1;
                t_reg <= t_reg ^ flip_n8;
            end
            else if (x_reg >= n_reg)
            begin
                x_reg <= x_reg - n_reg;
            end
            else
            begin
                x_reg <= n_reg - x_reg;
                n_reg <= x_reg;
                t_reg <= t_reg ^ ((x_reg[1:0] == 2'd3) && (n_reg[1:0] == 2'd3));
            end
        end
    end

    assign char_bit = bit_reg;
    assign status   = status_reg;

endmodule
`default_nettype wire
